// ----- rtl/core/thermocouple_to_fahrenheit_bcd_unit_defines.svh -----
// Assertion macros for the thermocouple to Fahrenheit BCD unit.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef THERMOCOUPLE_TO_FAHRENHEIT_BCD_UNIT_DEFINES_SVH
`define THERMOCOUPLE_TO_FAHRENHEIT_BCD_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TFB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tfb_pkg.sv -----
// Shared types, constants and functions of the thermocouple to Fahrenheit BCD unit.
// No dependencies.
`default_nettype none

package tfb_pkg;

  localparam int RawW      = 19;
  localparam int NumW      = 23;
  localparam int QuotW     = 15;
  localparam int MagW      = 12;
  localparam int FahrW     = 13;
  localparam int BcdW      = 16;
  localparam int HalfBits  = MagW / 2;
  localparam int RecipW    = 16;
  localparam int ProdW     = QuotW + RecipW;
  localparam int RecipShift = 18;
  localparam int FracShift = 7;

  // 32 degrees F expressed in 1/640 degree units.
  localparam logic signed [NumW-1:0] OffsetNum = 23'sd20480;
  // Half of 640, added before truncating division.
  localparam logic [NumW-1:0] HalfDen = 23'd320;
  // ceil(2^18 / 5): exact division by five for quotients below 2^16.
  localparam logic [RecipW-1:0] RecipFive = 16'd52429;

  typedef struct packed {
    logic signed [FahrW-1:0] fahrenheit;
    logic                    is_negative;
  } side_t;

  // One double-dabble step: correct every digit that is five or more, then shift a bit in.
  function automatic logic [BcdW-1:0] dabble_step(input logic [BcdW-1:0] b, input logic bit_in);
    logic [BcdW-1:0] c;
    c = b;
    for (int d = 0; d < BcdW / 4; d++) begin
      if (c[4*d +: 4] >= 4'd5) begin
        c[4*d +: 4] = c[4*d +: 4] + 4'd3;
      end
    end
    return {c[BcdW-2:0], bit_in};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/thermocouple_to_fahrenheit_bcd_unit.sv -----
// Top level of the thermocouple to Fahrenheit BCD unit.
// Depends on tfb_pkg, tfb_bcd and the assertion macro header.
`default_nettype none
`include "thermocouple_to_fahrenheit_bcd_unit_defines.svh"

// Converts a 19-bit two's-complement reading in 1/128 degree C, taken from the three
// converter bytes, to whole degrees Fahrenheit rounded half away from zero, with a sign
// flag and the magnitude as four packed BCD digits. Every item passes five register
// stages: scale and offset, absolute value with shift, multiply by the reciprocal of
// five, and two stages of six double-dabble steps each. One item is accepted in every
// cycle while the output is not stalled; each stage has its own valid bit and takes a
// new item whenever it is empty or its successor moves, so a stalled output only holds
// back the stages that are full.
module thermocouple_to_fahrenheit_bcd_unit import tfb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              high_byte_i,
  input  logic [7:0]              mid_byte_i,
  input  logic [7:0]              low_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [FahrW-1:0] fahrenheit_o,
  output logic                    is_negative_o,
  output logic [BcdW-1:0]         magnitude_bcd_o
);

  logic                   v1_q, v2_q, v3_q;
  logic                   rdy1, rdy2, rdy3, bcd_ready;
  logic signed [NumW-1:0] num_q, num_d;
  logic [QuotW-1:0]       quot_q, quot_d;
  logic                   nneg_q;
  logic [MagW-1:0]        mag_q, mag_d;
  side_t                  side_q, side_d, side_out;
  logic [RawW-1:0]        raw;
  logic signed [NumW-1:0] raw_ext;
  logic [NumW-1:0]        abs_num, rounded;
  logic [ProdW-1:0]       prod;

  assign rdy3       = !v3_q || bcd_ready;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    raw     = {high_byte_i, mid_byte_i, low_byte_i[7:5]};
    raw_ext = {{(NumW-RawW){raw[RawW-1]}}, raw};
    num_d   = (raw_ext <<< 3) + raw_ext + OffsetNum;

    abs_num = num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);
    rounded = abs_num + HalfDen;
    quot_d  = rounded[FracShift +: QuotW];

    prod  = ProdW'(quot_q) * ProdW'(RecipFive);
    mag_d = prod[RecipShift +: MagW];
    // A small negative numerator can round to zero, which is not negative.
    side_d.is_negative = nneg_q && (mag_d != '0);
    side_d.fahrenheit  = side_d.is_negative ? -$signed({1'b0, mag_d})
                                            : $signed({1'b0, mag_d});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      num_q <= num_d;
    end
    if (rdy2 && v1_q) begin
      quot_q <= quot_d;
      nneg_q <= num_q[NumW-1];
    end
    if (rdy3 && v2_q) begin
      mag_q  <= mag_d;
      side_q <= side_d;
    end
  end

  tfb_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .ready_o (bcd_ready),
    .mag_i   (mag_q),
    .side_i  (side_q),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .side_o  (side_out),
    .bcd_o   (magnitude_bcd_o)
  );

  assign fahrenheit_o  = side_out.fahrenheit;
  assign is_negative_o = side_out.is_negative;

  `TFB_ASSERT_SAME(a_sign_flag, out_valid_o, is_negative_o == fahrenheit_o[FahrW-1], "sign flag disagrees with result")
  `TFB_ASSERT_SAME(a_zero_result, out_valid_o && (fahrenheit_o == '0), (magnitude_bcd_o == '0) && !is_negative_o, "zero result has nonzero magnitude or sign")
  `TFB_ASSERT_SAME(a_bcd_digits, out_valid_o, (magnitude_bcd_o[3:0] <= 4'd9) && (magnitude_bcd_o[7:4] <= 4'd9) && (magnitude_bcd_o[11:8] <= 4'd9) && (magnitude_bcd_o[15:12] <= 4'd9), "BCD digit out of range")
  `TFB_ASSERT_NEXT(a_stage3_hold, v3_q && !bcd_ready, v3_q && $stable(mag_q), "stalled item lost in stage three")

endmodule

`default_nettype wire

// ----- rtl/core/tfb_bcd.sv -----
// Two-stage binary to packed BCD converter with handshake and a carried sideband.
// Depends on tfb_pkg.
`default_nettype none

module tfb_bcd import tfb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [MagW-1:0] mag_i,
  input  side_t           side_i,
  output logic            valid_o,
  input  logic            ready_i,
  output side_t           side_o,
  output logic [BcdW-1:0] bcd_o
);

  logic                va_q;
  logic [BcdW-1:0]     bcd_a_q, bcd_a_d;
  logic [HalfBits-1:0] rest_a_q;
  side_t               side_a_q;
  logic                vb_q;
  logic [BcdW-1:0]     bcd_b_q, bcd_b_d;
  side_t               side_b_q;
  logic                rdy_a, rdy_b;

  assign rdy_b   = !vb_q || ready_i;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;

  always_comb begin
    bcd_a_d = '0;
    for (int i = 0; i < HalfBits; i++) begin
      bcd_a_d = dabble_step(bcd_a_d, mag_i[MagW-1-i]);
    end
    bcd_b_d = bcd_a_q;
    for (int i = 0; i < HalfBits; i++) begin
      bcd_b_d = dabble_step(bcd_b_d, rest_a_q[HalfBits-1-i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      bcd_a_q  <= bcd_a_d;
      rest_a_q <= mag_i[HalfBits-1:0];
      side_a_q <= side_i;
    end
    if (rdy_b && va_q) begin
      bcd_b_q  <= bcd_b_d;
      side_b_q <= side_a_q;
    end
  end

  assign valid_o = vb_q;
  assign side_o  = side_b_q;
  assign bcd_o   = bcd_b_q;

endmodule

`default_nettype wire
